FILE: design/spc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sphere pair collision package
// Widths, reset values and the per-item sideband record shared by the
// collision pipeline.
// ----------------------------------------------------------------------------
package spc_pkg;

  // Width of one vector component, two's complement with 8 fraction bits.
  localparam int COMP_BITS = 16;
  localparam int VEC_W     = 3 * COMP_BITS;
  // Masses, radii and the time step are 16-bit unsigned fixed point.
  localparam int FIX_W     = 16;
  localparam int FRAC      = 16;

  localparam int DW        = COMP_BITS + 1;         // component difference
  localparam int SQW       = 2 * DW;                // square of a difference
  localparam int SUMW      = SQW + 2;               // sum of three squares
  localparam int MSW       = FIX_W + 1;             // radius or mass sum
  localparam int RSQW      = 2 * MSW;               // squared radius sum
  localparam int CMPW      = (SUMW > RSQW) ? SUMW : RSQW;
  localparam int PBW       = COMP_BITS + FIX_W + 1; // velocity times step
  localparam int Q1        = COMP_BITS + 19;        // ratio quotient bits
  localparam int NUMW      = SUMW + FRAC + 1;       // ratio dividend
  localparam int TMAGW     = COMP_BITS + 18;        // |ratio * d|
  localparam int MPW       = TMAGW + MSW;           // |ratio * d| * 2m
  localparam int Q2        = COMP_BITS + 5;         // velocity change bits
  localparam int DELW      = Q2 + 2;                // pre-saturation sum

  localparam int IN_W      = ((4 * VEC_W + 4 * FIX_W + 7) / 8) * 8;
  localparam int OUT_W     = ((4 * VEC_W + 7) / 8) * 8;

  localparam logic [FIX_W-1:0] TIME_STEP_RST = FIX_W'(1092);

  // Everything an item still needs later on, carried alongside the math.
  typedef struct packed {
    logic [VEC_W-1:0]       ca;    // center a (backed up once hit is known)
    logic [VEC_W-1:0]       cb;
    logic [VEC_W-1:0]       va;
    logic [VEC_W-1:0]       vb;
    logic [2:0][DW-1:0]     e;     // backed-up center difference
    logic [FIX_W-1:0]       ma;
    logic [FIX_W-1:0]       mb;
    logic [MSW-1:0]         msum;
    logic                   hit;
    logic                   resp;  // hit with usable direction and masses
    logic [2:0]             tneg;  // sign of ratio * d per component
  } side_t;

endpackage
`default_nettype wire

FILE: design/sphere_pair_elastic_collision.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sphere pair elastic collision
// Overlap test, center back-up and elastic velocity response for one pair.
// ----------------------------------------------------------------------------
// Usage: one sphere pair is a transfer on the in_ stream; every pair gives
// exactly one result transfer on the out_ stream, in order. The result
// carries the hit flag in out_tuser and the four vectors in out_tdata.
// The time step register is written through the cfg_ port, which is always
// ready; write it only while no pair is in flight.
// Throughput is one pair per cycle while the receiver takes results:
// the pipeline holds one item per stage, and its depth is set by the two
// bit-serial restoring dividers, one quotient bit per stage (the direction
// ratio, then six velocity-change lanes sharing the mass-sum divisor).
// The whole pipeline moves together; it stalls only when the output
// register holds a result that the receiver does not take, and then
// in_tready drops and every stage keeps its contents, so nothing is lost
// or repeated. Bubbles travel as cleared valid bits.
// Reset clears all valid bits and the output valid, and loads the time
// step with its default (1092, about 1/60 s in Q0.16).
// ----------------------------------------------------------------------------
module sphere_pair_elastic_collision (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Fields from bit 0 up: center_a, center_b, velocity_a, velocity_b,
  // mass_a, mass_b, radius_a, radius_b.
  input  wire logic [spc_pkg::IN_W-1:0]      in_tdata,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // Fields from bit 0 up: new_velocity_a, new_velocity_b, new_center_a,
  // new_center_b, zero padding.
  output logic [spc_pkg::OUT_W-1:0]          out_tdata,
  // Field: hit.
  output logic [0:0]                         out_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  input  wire logic [spc_pkg::FIX_W-1:0]     cfg_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready
);

  localparam int C     = spc_pkg::COMP_BITS;
  localparam int VEC_W = spc_pkg::VEC_W;
  localparam int FIX_W = spc_pkg::FIX_W;
  localparam int FRAC  = spc_pkg::FRAC;
  localparam int DW    = spc_pkg::DW;
  localparam int SQW   = spc_pkg::SQW;
  localparam int SUMW  = spc_pkg::SUMW;
  localparam int MSW   = spc_pkg::MSW;
  localparam int RSQW  = spc_pkg::RSQW;
  localparam int CMPW  = spc_pkg::CMPW;
  localparam int PBW   = spc_pkg::PBW;
  localparam int Q1    = spc_pkg::Q1;
  localparam int NUMW  = spc_pkg::NUMW;
  localparam int TMAGW = spc_pkg::TMAGW;
  localparam int MPW   = spc_pkg::MPW;
  localparam int Q2    = spc_pkg::Q2;
  localparam int DELW  = spc_pkg::DELW;
  localparam int OUT_W = spc_pkg::OUT_W;
  // Valid bits: five front stages, ratio divider, two multiply stages,
  // velocity divider.
  localparam int NV    = Q1 + Q2 + 9;
  localparam int V_D1  = 5;           // ratio divider entry stage
  localparam int V_M1  = 6 + Q1;

  // Saturate a wide signed value to one component.
  function automatic logic [C-1:0] sat_comp(input logic [DELW-1:0] x);
    logic [C-1:0] r;
    r = x[C-1:0];
    if (!x[DELW-1] && (|x[DELW-2:C-1])) begin
      r = {1'b0, {(C-1){1'b1}}};
    end else if (x[DELW-1] && !(&x[DELW-2:C-1])) begin
      r = {1'b1, {(C-1){1'b0}}};
    end
    return r;
  endfunction

  function automatic logic [DELW-1:0] ext_comp(input logic [C-1:0] v);
    return {{(DELW-C){v[C-1]}}, v};
  endfunction

  // --------------------------------------------------------------------------
  // Configuration and flow control
  // --------------------------------------------------------------------------
  logic [FIX_W-1:0] time_step_r;
  logic             adv;
  logic [NV-1:0]    vld_r;
  logic             out_valid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= spc_pkg::TIME_STEP_RST;
    end else if (cfg_valid) begin
      time_step_r <= cfg_data;
    end
  end

  // All stages advance together whenever the output register can move.
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NV-2:0], in_tvalid};
      out_valid_r <= vld_r[NV-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: center difference, radius sum, velocity times step
  // --------------------------------------------------------------------------
  logic [2:0][DW-1:0]   d1_r, d1_nxt;
  logic [2:0][PBW-1:0]  pa1_r, pa1_nxt, pb1_r, pb1_nxt;
  logic [MSW-1:0]       rs1_r, rs1_nxt;
  spc_pkg::side_t       sd1_r, sd1_nxt;

  always_comb begin
    logic [C-1:0] ca_c, cb_c, va_c, vb_c;
    sd1_nxt      = '0;
    sd1_nxt.ca   = in_tdata[0 +: VEC_W];
    sd1_nxt.cb   = in_tdata[VEC_W +: VEC_W];
    sd1_nxt.va   = in_tdata[2*VEC_W +: VEC_W];
    sd1_nxt.vb   = in_tdata[3*VEC_W +: VEC_W];
    sd1_nxt.ma   = in_tdata[4*VEC_W +: FIX_W];
    sd1_nxt.mb   = in_tdata[4*VEC_W + FIX_W +: FIX_W];
    rs1_nxt      = MSW'(in_tdata[4*VEC_W + 2*FIX_W +: FIX_W])
                 + MSW'(in_tdata[4*VEC_W + 3*FIX_W +: FIX_W]);
    for (int i = 0; i < 3; i++) begin
      ca_c       = sd1_nxt.ca[i*C +: C];
      cb_c       = sd1_nxt.cb[i*C +: C];
      va_c       = sd1_nxt.va[i*C +: C];
      vb_c       = sd1_nxt.vb[i*C +: C];
      d1_nxt[i]  = {ca_c[C-1], ca_c} - {cb_c[C-1], cb_c};
      pa1_nxt[i] = PBW'($signed({{(PBW-C){va_c[C-1]}}, va_c})
                      * $signed(PBW'(time_step_r)));
      pb1_nxt[i] = PBW'($signed({{(PBW-C){vb_c[C-1]}}, vb_c})
                      * $signed(PBW'(time_step_r)));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r  <= d1_nxt;
      pa1_r <= pa1_nxt;
      pb1_r <= pb1_nxt;
      rs1_r <= rs1_nxt;
      sd1_r <= sd1_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: squares, backed-up centers, velocity difference
  // --------------------------------------------------------------------------
  logic [2:0][SQW-1:0]  dsq2_r, dsq2_nxt;
  logic [RSQW-1:0]      rsq2_r, rsq2_nxt;
  logic [2:0][C-1:0]    nca2_r, nca2_nxt, ncb2_r, ncb2_nxt;
  logic [2:0][DW-1:0]   dv2_r, dv2_nxt;
  spc_pkg::side_t       sd2_r;

  // Center minus product / 2^16, rounded half away from zero, saturated.
  function automatic logic [C-1:0] back_up(input logic [C-1:0] c,
                                           input logic [PBW-1:0] p);
    logic [PBW-1:0]  mag;
    logic [PBW:0]    sum;
    logic [DELW-1:0] q;
    mag = p[PBW-1] ? (~p + PBW'(1)) : p;
    sum = {1'b0, mag} + ((PBW+1)'(1) << (FRAC - 1));
    q   = DELW'(sum[PBW:FRAC]);
    if (p[PBW-1]) begin
      q = ~q + DELW'(1);
    end
    return sat_comp(ext_comp(c) - q);
  endfunction

  always_comb begin
    logic [SQW-1:0] dx;
    logic [C-1:0]   va_c, vb_c;
    rsq2_nxt = RSQW'(rs1_r) * RSQW'(rs1_r);
    for (int i = 0; i < 3; i++) begin
      dx          = {{(SQW-DW){d1_r[i][DW-1]}}, d1_r[i]};
      dsq2_nxt[i] = dx * dx;
      nca2_nxt[i] = back_up(sd1_r.ca[i*C +: C], pa1_r[i]);
      ncb2_nxt[i] = back_up(sd1_r.cb[i*C +: C], pb1_r[i]);
      va_c        = sd1_r.va[i*C +: C];
      vb_c        = sd1_r.vb[i*C +: C];
      dv2_nxt[i]  = {va_c[C-1], va_c} - {vb_c[C-1], vb_c};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dsq2_r <= dsq2_nxt;
      rsq2_r <= rsq2_nxt;
      nca2_r <= nca2_nxt;
      ncb2_r <= ncb2_nxt;
      dv2_r  <= dv2_nxt;
      sd2_r  <= sd1_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: overlap test, choose centers, new center difference
  // --------------------------------------------------------------------------
  logic [2:0][DW-1:0]   dv3_r;
  spc_pkg::side_t       sd3_r, sd3_nxt;

  always_comb begin
    logic [CMPW-1:0] dist2;
    logic            hit;
    dist2   = CMPW'(dsq2_r[0]) + CMPW'(dsq2_r[1]) + CMPW'(dsq2_r[2]);
    hit     = dist2 < CMPW'(rsq2_r);
    sd3_nxt = sd2_r;
    sd3_nxt.hit = hit;
    for (int i = 0; i < 3; i++) begin
      sd3_nxt.e[i] = {nca2_r[i][C-1], nca2_r[i]} - {ncb2_r[i][C-1], ncb2_r[i]};
      if (hit) begin
        sd3_nxt.ca[i*C +: C] = nca2_r[i];
        sd3_nxt.cb[i*C +: C] = ncb2_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv3_r <= dv2_r;
      sd3_r <= sd3_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: products for the dot product and the squared norm
  // --------------------------------------------------------------------------
  logic [2:0][SQW-1:0]  ed4_r, ed4_nxt, ee4_r, ee4_nxt;
  spc_pkg::side_t       sd4_r;

  always_comb begin
    logic [SQW-1:0] ex, vx;
    for (int i = 0; i < 3; i++) begin
      ex         = {{(SQW-DW){sd3_r.e[i][DW-1]}}, sd3_r.e[i]};
      vx         = {{(SQW-DW){dv3_r[i][DW-1]}}, dv3_r[i]};
      ed4_nxt[i] = vx * ex;
      ee4_nxt[i] = ex * ex;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ed4_r <= ed4_nxt;
      ee4_r <= ee4_nxt;
      sd4_r <= sd3_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: dot product, squared norm, mass sum
  // --------------------------------------------------------------------------
  logic [SUMW-1:0]      dot5_r, dot5_nxt, nrm5_r, nrm5_nxt;
  spc_pkg::side_t       sd5_r, sd5_nxt;

  always_comb begin
    dot5_nxt = '0;
    nrm5_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      dot5_nxt = dot5_nxt + {{(SUMW-SQW){ed4_r[i][SQW-1]}}, ed4_r[i]};
      nrm5_nxt = nrm5_nxt + SUMW'(ee4_r[i]);
    end
    sd5_nxt      = sd4_r;
    sd5_nxt.msum = MSW'(sd4_r.ma) + MSW'(sd4_r.mb);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dot5_r <= dot5_nxt;
      nrm5_r <= nrm5_nxt;
      sd5_r  <= sd5_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Ratio divider: |dot| * 2^16 + norm/2 over norm, one quotient bit a stage.
  // Entry 0 loads the rounded dividend; the quotient shifts into word1_r.
  // --------------------------------------------------------------------------
  logic [SUMW-1:0]      rem1_r  [0:Q1];
  logic [Q1-1:0]        word1_r [0:Q1];
  logic [SUMW-1:0]      den1_r  [0:Q1];
  logic                 neg1_r  [0:Q1];
  spc_pkg::side_t       sd1d_r  [0:Q1];

  always_ff @(posedge clk) begin
    logic [SUMW-1:0] mag;
    logic [NUMW-1:0] num;
    spc_pkg::side_t  sd;
    if (adv) begin
      mag = dot5_r[SUMW-1] ? (~dot5_r + SUMW'(1)) : dot5_r;
      num = (NUMW'(mag) << FRAC) + NUMW'(nrm5_r >> 1);
      sd      = sd5_r;
      sd.resp = sd5_r.hit && (nrm5_r != '0) && (sd5_r.msum != '0);
      rem1_r[0]  <= SUMW'(num[NUMW-1:Q1]);
      word1_r[0] <= num[Q1-1:0];
      den1_r[0]  <= nrm5_r;
      neg1_r[0]  <= dot5_r[SUMW-1];
      sd1d_r[0]  <= sd;
    end
  end

  for (genvar k = 1; k <= Q1; k++) begin : g_div1
    logic [SUMW:0] cat;
    logic          ge;
    assign cat = {rem1_r[k-1], word1_r[k-1][Q1-1]};
    assign ge  = cat >= {1'b0, den1_r[k-1]};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem1_r[k]  <= ge ? SUMW'(cat - {1'b0, den1_r[k-1]}) : SUMW'(cat);
        word1_r[k] <= {word1_r[k-1][Q1-2:0], ge};
        den1_r[k]  <= den1_r[k-1];
        neg1_r[k]  <= neg1_r[k-1];
        sd1d_r[k]  <= sd1d_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Multiply stage 1: |ratio * d| and its sign per component
  // --------------------------------------------------------------------------
  logic [2:0][TMAGW-1:0] tm1_r, tm1_nxt;
  spc_pkg::side_t        sdm1_r, sdm1_nxt;

  always_comb begin
    logic [DW-1:0]    emag;
    logic [Q1+DW-1:0] prod;
    sdm1_nxt = sd1d_r[Q1];
    for (int i = 0; i < 3; i++) begin
      emag = sd1d_r[Q1].e[i][DW-1] ? (~sd1d_r[Q1].e[i] + DW'(1)) : sd1d_r[Q1].e[i];
      prod = (Q1+DW)'(word1_r[Q1]) * (Q1+DW)'(emag);
      tm1_nxt[i] = prod[TMAGW-1:0];
      sdm1_nxt.tneg[i] = neg1_r[Q1] ^ sd1d_r[Q1].e[i][DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tm1_r  <= tm1_nxt;
      sdm1_r <= sdm1_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Multiply stage 2: times twice the other body's mass
  // --------------------------------------------------------------------------
  logic [5:0][MPW-1:0] mp2_r, mp2_nxt;
  spc_pkg::side_t      sdm2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mp2_nxt[i]   = MPW'(tm1_r[i]) * MPW'({sdm1_r.mb, 1'b0});
      mp2_nxt[3+i] = MPW'(tm1_r[i]) * MPW'({sdm1_r.ma, 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mp2_r  <= mp2_nxt;
      sdm2_r <= sdm1_r;
    end
  end

  // --------------------------------------------------------------------------
  // Velocity divider: six lanes (a x,y,z then b x,y,z) over the mass sum.
  // Rounding by msum * 2^16 equals adding half of it, dropping 16 bits and
  // dividing by msum. Entry 0 does that pre-scaling.
  // --------------------------------------------------------------------------
  logic [5:0][MSW-1:0] rem2_r  [0:Q2];
  logic [5:0][Q2-1:0]  word2_r [0:Q2];
  spc_pkg::side_t      sd2d_r  [0:Q2];

  always_ff @(posedge clk) begin
    logic [MPW:0] y;
    if (adv) begin
      for (int j = 0; j < 6; j++) begin
        y = (MPW+1)'(mp2_r[j]) + ((MPW+1)'(sdm2_r.msum) << (FRAC - 1));
        rem2_r[0][j]  <= MSW'(y[MPW:FRAC+Q2]);
        word2_r[0][j] <= y[FRAC+Q2-1:FRAC];
      end
      sd2d_r[0] <= sdm2_r;
    end
  end

  for (genvar k = 1; k <= Q2; k++) begin : g_div2
    for (genvar j = 0; j < 6; j++) begin : g_lane
      logic [MSW:0] cat;
      logic         ge;
      assign cat = {rem2_r[k-1][j], word2_r[k-1][j][Q2-1]};
      assign ge  = cat >= {1'b0, sd2d_r[k-1].msum};
      always_ff @(posedge clk) begin
        if (adv) begin
          rem2_r[k][j]  <= ge ? MSW'(cat - {1'b0, sd2d_r[k-1].msum}) : MSW'(cat);
          word2_r[k][j] <= {word2_r[k-1][j][Q2-2:0], ge};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sd2d_r[k] <= sd2d_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: apply the velocity change and saturate
  // --------------------------------------------------------------------------
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  logic             out_hit_r;

  always_comb begin
    spc_pkg::side_t   sd;
    logic [VEC_W-1:0] nva, nvb;
    logic [DELW-1:0]  qa, qb;
    sd  = sd2d_r[Q2];
    nva = sd.va;
    nvb = sd.vb;
    for (int i = 0; i < 3; i++) begin
      qa = DELW'(word2_r[Q2][i]);
      qb = DELW'(word2_r[Q2][3+i]);
      if (sd.tneg[i]) begin
        qa = ~qa + DELW'(1);
        qb = ~qb + DELW'(1);
      end
      if (sd.resp) begin
        nva[i*C +: C] = sat_comp(ext_comp(sd.va[i*C +: C]) - qa);
        nvb[i*C +: C] = sat_comp(ext_comp(sd.vb[i*C +: C]) + qb);
      end
    end
    out_data_nxt = OUT_W'({sd.cb, sd.ca, nvb, nva});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
      out_hit_r  <= sd2d_r[Q2].hit;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_hit_r;
  assign out_tvalid = out_valid_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r) && $stable(out_valid_r))
    else $error("pipeline valid bits moved during a stall");

  a_resp_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NV-1] && sd2d_r[Q2].resp |-> sd2d_r[Q2].hit)
    else $error("velocity response applied without a hit");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !vld_r[0])
    else $error("pipeline not empty after reset");

  a_bubble_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !vld_r[NV-1] |=> !out_tvalid)
    else $error("result presented for a bubble");

  a_ratio_entry: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld_r[V_D1-1] |=> vld_r[V_D1] && vld_r[V_M1-1] == $past(vld_r[V_M1-2]))
    else $error("ratio divider lost track of an item");

endmodule
`default_nettype wire

FILE: tb/sphere_pair_elastic_collision_tb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sphere pair elastic collision testbench
// Streams sphere pairs into the block under several time step settings and
// compares every result transfer with a collision predictor computed inside
// the testbench. Both stream sides idle at random in some phases, the
// receiver holds off for a long stretch once, and phases end in a drain.
// ----------------------------------------------------------------------------
module sphere_pair_elastic_collision_tb;

  localparam int CB      = spc_pkg::COMP_BITS;
  localparam int FIX_W   = spc_pkg::FIX_W;
  localparam int VEC_W   = spc_pkg::VEC_W;
  localparam int IN_W    = spc_pkg::IN_W;
  localparam int OUT_W   = spc_pkg::OUT_W;
  localparam int LATENCY = spc_pkg::Q1 + spc_pkg::Q2 + 10;

  // One sphere pair as it travels on in_tdata.
  typedef struct packed {
    logic [FIX_W-1:0] rb;
    logic [FIX_W-1:0] ra;
    logic [FIX_W-1:0] mb;
    logic [FIX_W-1:0] ma;
    logic [VEC_W-1:0] vb;
    logic [VEC_W-1:0] va;
    logic [VEC_W-1:0] cb;
    logic [VEC_W-1:0] ca;
  } pair_t;

  // One collision response: hit flag and the four vectors.
  typedef struct packed {
    logic             hit;
    logic [VEC_W-1:0] ncb;
    logic [VEC_W-1:0] nca;
    logic [VEC_W-1:0] nvb;
    logic [VEC_W-1:0] nva;
  } response_t;

  logic               clk;
  logic               rst_n;
  logic [IN_W-1:0]    in_tdata;
  logic               in_tvalid;
  logic               in_tready;
  logic [OUT_W-1:0]   out_tdata;
  logic [0:0]         out_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic [FIX_W-1:0]   cfg_data;
  logic               cfg_valid;
  logic               cfg_ready;

  sphere_pair_elastic_collision i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Predictor copy of the time step register.
  logic [FIX_W-1:0] step_q16;

  pair_t     pending_pairs[$];
  response_t expected_responses[$];
  int        mismatch_count;
  bit        stimulus_done;
  bit        in_idle_ok;     // random gaps on the sending side
  bit        out_idle_ok;    // random stalls on the receiving side
  int        hold_off_cycles;
  bit        in_accepted;    // the offered pair was taken at the last edge

  function automatic longint comp_of(logic [VEC_W-1:0] v, int i);
    logic signed [CB-1:0] c;
    c = v[i*CB +: CB];
    return longint'(c);
  endfunction

  function automatic longint clamp_comp(longint v);
    longint hi;
    hi = (longint'(1) <<< (CB - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Division with the quotient rounded half away from zero.
  function automatic longint div_half_away(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + (den >>> 1)) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic response_t collide(pair_t p, logic [FIX_W-1:0] dt);
    response_t r;
    longint ca[3], cb[3], va[3], vb[3], nca[3], ncb[3], nva[3], nvb[3], d[3];
    longint dist2, rsum, dot, nrm, msum, s, t, da, db;
    dist2 = 0;
    for (int i = 0; i < 3; i++) begin
      ca[i] = comp_of(p.ca, i);
      cb[i] = comp_of(p.cb, i);
      va[i] = comp_of(p.va, i);
      vb[i] = comp_of(p.vb, i);
      nca[i] = ca[i];
      ncb[i] = cb[i];
      nva[i] = va[i];
      nvb[i] = vb[i];
      dist2 += (ca[i] - cb[i]) * (ca[i] - cb[i]);
    end
    rsum = longint'(p.ra) + longint'(p.rb);
    r.hit = dist2 < rsum * rsum;
    if (r.hit) begin
      dot = 0;
      nrm = 0;
      for (int i = 0; i < 3; i++) begin
        nca[i] = clamp_comp(ca[i] - div_half_away(va[i] * longint'(dt), 64'sd65536));
        ncb[i] = clamp_comp(cb[i] - div_half_away(vb[i] * longint'(dt), 64'sd65536));
        d[i] = nca[i] - ncb[i];
        nrm += d[i] * d[i];
        dot += (va[i] - vb[i]) * d[i];
      end
      msum = longint'(p.ma) + longint'(p.mb);
      // Coinciding moved-back centers leave the velocities untouched.
      if (nrm != 0 && msum != 0) begin
        s = div_half_away(dot * 65536, nrm);
        for (int i = 0; i < 3; i++) begin
          t = s * d[i];
          da = div_half_away(t * 2 * longint'(p.mb), msum * 65536);
          db = div_half_away(t * 2 * longint'(p.ma), msum * 65536);
          nva[i] = clamp_comp(va[i] - da);
          nvb[i] = clamp_comp(vb[i] + db);
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      r.nca[i*CB +: CB] = nca[i][CB-1:0];
      r.ncb[i*CB +: CB] = ncb[i][CB-1:0];
      r.nva[i*CB +: CB] = nva[i][CB-1:0];
      r.nvb[i*CB +: CB] = nvb[i][CB-1:0];
    end
    return r;
  endfunction

  function automatic logic [VEC_W-1:0] rand_vec(int span);
    logic [VEC_W-1:0] v;
    for (int i = 0; i < 3; i++) begin
      v[i*CB +: CB] = CB'($urandom_range(2 * span) - span);
    end
    return v;
  endfunction

  function automatic logic [VEC_W-1:0] rand_full_vec();
    return VEC_W'({$urandom, $urandom});
  endfunction

  // Pairs placed close together so that most of them overlap.
  function automatic pair_t near_pair();
    pair_t p;
    p.ca = rand_vec(4000);
    p.cb = p.ca + rand_vec(600);
    p.va = rand_vec(2000);
    p.vb = rand_vec(2000);
    p.ma = FIX_W'($urandom_range(65535, 1));
    p.mb = FIX_W'($urandom_range(65535, 1));
    p.ra = FIX_W'($urandom_range(800));
    p.rb = FIX_W'($urandom_range(800));
    // Wrap a component now and then to reach the saturation corners.
    if ($urandom_range(9) == 0) p.cb[CB-1] = ~p.cb[CB-1];
    return p;
  endfunction

  function automatic pair_t wild_pair();
    pair_t p;
    p.ca = rand_full_vec();
    p.cb = rand_full_vec();
    p.va = rand_full_vec();
    p.vb = rand_full_vec();
    p.ma = FIX_W'($urandom_range(65535, 1));
    p.mb = FIX_W'($urandom_range(65535, 1));
    p.ra = FIX_W'($urandom);
    p.rb = FIX_W'($urandom);
    return p;
  endfunction

  // Remembers whether the offered pair was taken at the rising edge.
  always @(posedge clk) begin
    in_accepted <= rst_n && in_tvalid && in_tready;
  end

  // Driver: inputs change on the falling edge only.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_accepted) begin
      // Hold the offered pair until the block takes it.
    end else if (pending_pairs.size() != 0 &&
                 !(in_idle_ok && $urandom_range(99) < 25)) begin
      in_tdata  <= pending_pairs.pop_front();
      in_tvalid <= 1'b1;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Receiver readiness, including the long hold-off counted here.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready      <= 1'b0;
    end else begin
      out_tready <= !(out_idle_ok && $urandom_range(99) < 25);
    end
  end

  // Predictor on accepted input transfers, checker on result transfers.
  always @(posedge clk) begin
    response_t got, want;
    if (rst_n && in_tvalid && in_tready) begin
      expected_responses.push_back(collide(pair_t'(in_tdata), step_q16));
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[0], out_tdata[4*VEC_W-1:0]};
      if (expected_responses.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result transfer %h", $time, got);
      end else begin
        want = expected_responses.pop_front();
        if (got.hit !== want.hit) begin
          mismatch_count++;
          $display("%0t: hit expected %b actual %b", $time, want.hit, got.hit);
        end
        if (got.nva !== want.nva) begin
          mismatch_count++;
          $display("%0t: new_velocity_a expected %h actual %h", $time, want.nva, got.nva);
        end
        if (got.nvb !== want.nvb) begin
          mismatch_count++;
          $display("%0t: new_velocity_b expected %h actual %h", $time, want.nvb, got.nvb);
        end
        if (got.nca !== want.nca) begin
          mismatch_count++;
          $display("%0t: new_center_a expected %h actual %h", $time, want.nca, got.nca);
        end
        if (got.ncb !== want.ncb) begin
          mismatch_count++;
          $display("%0t: new_center_b expected %h actual %h", $time, want.ncb, got.ncb);
        end
      end
    end
  end

  // Waits until everything sent has come back and the pipeline is empty.
  task automatic drain_pipeline();
    while (pending_pairs.size() != 0 || in_tvalid || expected_responses.size() != 0) begin
      @(posedge clk);
    end
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Writes the time step while the block is idle.
  task automatic write_step(logic [FIX_W-1:0] value);
    @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    step_q16 = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Queues one random phase of mostly overlapping pairs.
  task automatic queue_random(int count);
    for (int n = 0; n < count; n++) begin
      pending_pairs.push_back(($urandom_range(99) < 75) ? near_pair() : wild_pair());
    end
  endtask

  initial begin
    pair_t p;
    logic [VEC_W-1:0] max_v, min_v;
    rst_n           = 1'b0;
    in_tdata        = '0;
    in_tvalid       = 1'b0;
    out_tready      = 1'b0;
    cfg_data        = '0;
    cfg_valid       = 1'b0;
    mismatch_count  = 0;
    stimulus_done   = 1'b0;
    in_idle_ok      = 1'b0;
    out_idle_ok     = 1'b0;
    hold_off_cycles = 0;
    in_accepted     = 1'b0;
    step_q16        = spc_pkg::TIME_STEP_RST;
    max_v = {3{CB'(16'h7fff)}};
    min_v = {3{CB'(16'h8000)}};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed pairs under the reset time step, with no idling at all.
    // Far apart: no hit, everything passes through.
    p = '{ca: '0, cb: {3{CB'(16'h0400)}}, va: max_v, vb: min_v,
          ma: 16'h0100, mb: 16'h0100, ra: 16'h0100, rb: 16'h0100};
    pending_pairs.push_back(p);
    // Touching exactly: distance equals the radius sum, which is no hit.
    p = '{ca: '0, cb: {32'h0, CB'(16'h0200)}, va: '0, vb: '0,
          ma: 16'h0100, mb: 16'h0100, ra: 16'h0100, rb: 16'h0100};
    pending_pairs.push_back(p);
    // Head-on hit along x with equal masses.
    p = '{ca: '0, cb: {32'h0, CB'(16'h0100)}, va: {32'h0, CB'(16'h0100)},
          vb: {32'h0, CB'(16'hff00)}, ma: 16'h0100, mb: 16'h0100,
          ra: 16'h0100, rb: 16'h0100};
    pending_pairs.push_back(p);
    // Coinciding centers with equal velocities: the direction vanishes.
    p = '{ca: {3{CB'(16'h1234)}}, cb: {3{CB'(16'h1234)}}, va: '0, vb: '0,
          ma: 16'h0001, mb: 16'hffff, ra: 16'h0010, rb: 16'h0000};
    pending_pairs.push_back(p);
    // Extreme corners: centers at or near the limits, opposite saturated velocities.
    p = '{ca: max_v, cb: max_v, va: min_v, vb: max_v,
          ma: 16'hffff, mb: 16'h0001, ra: 16'hffff, rb: 16'hffff};
    pending_pairs.push_back(p);
    p = '{ca: min_v, cb: max_v, va: max_v, vb: min_v,
          ma: 16'hffff, mb: 16'hffff, ra: 16'hffff, rb: 16'hffff};
    pending_pairs.push_back(p);
    p = '{ca: min_v, cb: min_v + 1, va: min_v, vb: max_v,
          ma: 16'h0001, mb: 16'h0001, ra: 16'h0000, rb: 16'h0001};
    pending_pairs.push_back(p);
    // Zero radii: never a hit, even at the same center.
    p = '{ca: '1, cb: '1, va: '1, vb: '0,
          ma: 16'h0001, mb: 16'h0001, ra: 16'h0000, rb: 16'h0000};
    pending_pairs.push_back(p);
    for (int n = 0; n < 8; n++) pending_pairs.push_back(wild_pair());
    drain_pipeline();

    // Phase: shortest time step, random idling on both sides.
    write_step(16'h0000);
    in_idle_ok  = 1'b1;
    out_idle_ok = 1'b1;
    queue_random(250);
    drain_pipeline();

    // Phase: longest time step. The receiver holds off long enough that
    // the pipeline fills and in_tready drops while the sender keeps going.
    write_step(16'hffff);
    @(negedge clk);
    hold_off_cycles = 3 * LATENCY;
    queue_random(250);
    drain_pipeline();

    // Phase: random time steps with no idling on either side, a drain after
    // every burst.
    in_idle_ok  = 1'b0;
    out_idle_ok = 1'b0;
    for (int k = 0; k < 3; k++) begin
      write_step(FIX_W'($urandom));
      queue_random(100);
      drain_pipeline();
    end

    // Back to the reset value for the last phase.
    in_idle_ok  = 1'b1;
    out_idle_ok = 1'b1;
    write_step(spc_pkg::TIME_STEP_RST);
    queue_random(200);
    drain_pipeline();
    stimulus_done = 1'b1;
  end

  initial begin
    wait (stimulus_done);
    if (mismatch_count == 0) begin
      $display("sphere_pair_elastic_collision: match");
    end else begin
      $display("sphere_pair_elastic_collision: mismatch");
    end
    $finish;
  end

  // Run limit, far above a fully stalled run of all pairs.
  initial begin
    #5_000_000;
    $display("sphere_pair_elastic_collision: mismatch");
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
design/spc_pkg.sv
design/sphere_pair_elastic_collision.sv
tb/sphere_pair_elastic_collision_tb.sv
